@@ sv/tcd_pkg.sv @@
// Shared types and constants for the text character decoder.
// Used by every module of the decoder; depends on nothing else.
`default_nettype none
package tcd_pkg;

	typedef enum logic [1:0] {
		ENC_ASCII = 2'd0,
		ENC_UTF8  = 2'd1,
		ENC_UTF16 = 2'd2,
		ENC_UTF32 = 2'd3
	} enc_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENCODING   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 2'd1;

	localparam logic [15:0] SURR_MASK = 16'hfc00;
	localparam logic [15:0] SURR_HIGH = 16'hd800;
	localparam logic [15:0] SURR_LOW  = 16'hdc00;
	localparam logic [15:0] SURR_BITS = 16'h03ff;
	localparam logic [31:0] SUPP_BASE = 32'h0001_0000;
	localparam logic [7:0]  CONT_MASK = 8'hc0;
	localparam logic [7:0]  CONT_TAG  = 8'h80;
	localparam logic [7:0]  CONT_BITS = 8'h3f;

	typedef struct packed {
		enc_t encoding;
		logic big_endian;
	} cfg_t;

	typedef struct packed {
		logic [31:0] acc;
		logic [1:0]  remaining;
		logic [1:0]  unit_idx;
		logic [9:0]  high_surr;
		logic        have_high;
		logic        seq_err;
	} dec_state_t;

	typedef struct packed {
		logic [31:0] code_point;
		logic        malformed;
	} result_t;

endpackage
`default_nettype wire

@@ sv/tcd_cfg.sv @@
// Configuration registers of the text character decoder.
// Depends on tcd_pkg; raises a clear pulse on every write to a known register.
`default_nettype none
module tcd_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [tcd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [tcd_pkg::CFG_DATA_W-1:0] wr_data,
	output tcd_pkg::cfg_t                       cfg,
	output logic                                clear
);

	tcd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encoding   <= tcd_pkg::ENC_ASCII;
			cfg_q.big_endian <= 1'b0;
		end else if (wr_en) begin
			if (wr_index == tcd_pkg::CFG_ENCODING) begin
				cfg_q.encoding <= tcd_pkg::enc_t'(wr_data[1:0]);
			end else if (wr_index == tcd_pkg::CFG_BIG_ENDIAN) begin
				cfg_q.big_endian <= wr_data[0];
			end
		end
	end

	assign cfg   = cfg_q;
	assign clear = wr_en && (wr_index == tcd_pkg::CFG_ENCODING ||
		wr_index == tcd_pkg::CFG_BIG_ENDIAN);

endmodule
`default_nettype wire

@@ sv/tcd_decode.sv @@
// Decoding state and the single-pass next-state and result logic.
// Depends on tcd_pkg; one byte is decoded in each cycle it is accepted.
`default_nettype none
module tcd_decode (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire tcd_pkg::cfg_t cfg,
	input  wire logic         clear,
	input  wire logic         in_valid,
	input  wire logic [7:0]   data_byte,
	output logic              res_valid,
	output tcd_pkg::result_t  res
);

	tcd_pkg::dec_state_t state_q;
	tcd_pkg::dec_state_t nxt;

	always_comb begin
		logic [31:0] gathered;
		logic [2:0]  idx_inc;
		logic        unit_done;
		logic [15:0] unit;
		logic        cont_bad;
		logic [31:0] cp;
		logic        bad;
		logic        emit;

		nxt      = state_q;
		emit     = 1'b0;
		cp       = 32'd0;
		bad      = 1'b0;

		if (cfg.big_endian) begin
			gathered = {state_q.acc[23:0], data_byte};
		end else begin
			gathered = state_q.acc | ({24'd0, data_byte} << {state_q.unit_idx, 3'b000});
		end
		idx_inc  = {1'b0, state_q.unit_idx} + 3'd1;
		unit     = gathered[15:0];
		cont_bad = (data_byte == 8'd0) ||
			((data_byte & tcd_pkg::CONT_MASK) != tcd_pkg::CONT_TAG);
		unit_done = 1'b0;

		unique case (cfg.encoding)
			tcd_pkg::ENC_ASCII: begin
				emit = 1'b1;
				cp   = {24'd0, data_byte};
			end
			tcd_pkg::ENC_UTF8: begin
				if (state_q.remaining != 2'd0) begin
					nxt.seq_err   = state_q.seq_err | cont_bad;
					nxt.acc       = {state_q.acc[25:0], data_byte[5:0] & tcd_pkg::CONT_BITS[5:0]};
					nxt.remaining = state_q.remaining - 2'd1;
					if (state_q.remaining == 2'd1) begin
						emit        = 1'b1;
						cp          = nxt.acc;
						bad         = nxt.seq_err;
						nxt.acc     = 32'd0;
						nxt.seq_err = 1'b0;
					end
				end else begin
					priority casez (data_byte)
						8'b0???_????: begin
							emit = 1'b1;
							cp   = {24'd0, data_byte};
						end
						8'b110?_????: begin
							nxt.acc       = {27'd0, data_byte[4:0]};
							nxt.remaining = 2'd1;
							nxt.seq_err   = 1'b0;
						end
						8'b1110_????: begin
							nxt.acc       = {28'd0, data_byte[3:0]};
							nxt.remaining = 2'd2;
							nxt.seq_err   = 1'b0;
						end
						8'b1111_0???: begin
							nxt.acc       = {29'd0, data_byte[2:0]};
							nxt.remaining = 2'd3;
							nxt.seq_err   = 1'b0;
						end
						default: begin
							emit = 1'b1;
							bad  = 1'b1;
						end
					endcase
				end
			end
			tcd_pkg::ENC_UTF16: begin
				unit_done    = idx_inc >= 3'd2;
				nxt.acc      = unit_done ? 32'd0 : gathered;
				nxt.unit_idx = unit_done ? 2'd0 : idx_inc[1:0];
				if (unit_done) begin
					if (state_q.have_high) begin
						nxt.have_high = 1'b0;
						nxt.high_surr = 10'd0;
						emit          = 1'b1;
						bad           = (unit & tcd_pkg::SURR_MASK) != tcd_pkg::SURR_LOW;
						cp            = tcd_pkg::SUPP_BASE + {12'd0, state_q.high_surr, unit[9:0]};
					end else if ((unit & tcd_pkg::SURR_MASK) == tcd_pkg::SURR_HIGH) begin
						nxt.have_high = 1'b1;
						nxt.high_surr = unit[9:0] & tcd_pkg::SURR_BITS[9:0];
					end else begin
						emit = 1'b1;
						cp   = {16'd0, unit};
					end
				end
			end
			tcd_pkg::ENC_UTF32: begin
				unit_done    = idx_inc >= 3'd4;
				nxt.acc      = unit_done ? 32'd0 : gathered;
				nxt.unit_idx = unit_done ? 2'd0 : idx_inc[1:0];
				emit         = unit_done;
				cp           = gathered;
			end
			default: begin
				emit = 1'b0;
			end
		endcase

		res_valid      = in_valid && emit;
		res.malformed  = bad;
		res.code_point = bad ? 32'd0 : cp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (clear) begin
			state_q <= '0;
		end else if (in_valid) begin
			state_q <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ sv/tcd_out_buf.sv @@
// Two-word output buffer that separates the decoder from the output stream.
// Depends on tcd_pkg; input is refused only when both words are occupied.
`default_nettype none
module tcd_out_buf (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire tcd_pkg::result_t push_data,
	output logic              has_room,
	output logic              out_valid,
	input  wire logic         out_ready,
	output tcd_pkg::result_t  out_data
);

	logic             out_valid_q;
	tcd_pkg::result_t out_data_q;
	logic             skid_valid_q;
	tcd_pkg::result_t skid_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign has_room  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

@@ sv/text_character_decoder_top.sv @@
// Top level of the text character decoder.
// Instantiates tcd_cfg, tcd_decode and tcd_out_buf; uses tcd_pkg.
`default_nettype none
// The decoder takes one byte of ASCII, UTF-8, UTF-16 or UTF-32 text per
// cycle while s_tready is high and delivers each character's code point
// registered, with tuser set when the sequence was malformed. Each byte
// is decoded in a single pass into a two-word output buffer, so s_tready
// stays high unless both buffer words are waiting on the output side.
// Writing either configuration register drops any partly decoded
// character; writes are meant to happen only while the decoder is idle.
module text_character_decoder_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,   // data_byte
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [31:0]                         m_tdata,   // code_point
	output logic [0:0]                          m_tuser,   // malformed
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tcd_pkg::CFG_DATA_W-1:0] cfg_data
);

	tcd_pkg::cfg_t    cfg;
	logic             clear;
	logic             accept;
	logic             res_valid;
	tcd_pkg::result_t res;
	tcd_pkg::result_t out_word;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	tcd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.clear    (clear)
	);

	tcd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.clear     (clear),
		.in_valid  (accept),
		.data_byte (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	tcd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.has_room  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_word)
	);

	assign m_tdata = out_word.code_point;
	assign m_tuser = out_word.malformed;

endmodule
`default_nettype wire

@@ sv/tcd_checker.sv @@
// Port-level checks for the text character decoder and their binding.
// Depends only on the ports of text_character_decoder_top.
`default_nettype none
module tcd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	a_malformed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
		else $error("Malformed word carries a non-zero code point.");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("Input refused while no output word is waiting.");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Output word withdrawn before it was taken.");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("Output word changed while stalled.");

endmodule

bind text_character_decoder_top tcd_checker u_tcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

@@ tb/sv/code_point_checker.sv @@
`timescale 1ns / 100ps
// Watches the byte, code point and register channels of the text character decoder,
// models the decoding of every accepted byte and compares each delivered code point.
// Depends on tcd_pkg for the encoding names, register indexes and the result layout.
module code_point_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [7:0]                     s_tdata,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [31:0]                    m_tdata,
	input  wire logic [0:0]                     m_tuser,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [tcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tcd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  open_results,
	output int                                  mismatch_count
);
	import tcd_pkg::*;

	enc_t        enc_mode;
	logic        msb_first;
	logic [31:0] partial;
	logic [1:0]  cont_left;
	logic [1:0]  unit_pos;
	logic [9:0]  pend_high;
	logic        pend_high_valid;
	logic        cont_bad;
	result_t     expected_chars[$];

	task automatic report_mismatch(input string what);
		$display("%0t code point check: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic clear_decode();
		partial = '0;
		cont_left = '0;
		unit_pos = '0;
		pend_high = '0;
		pend_high_valid = 1'b0;
		cont_bad = 1'b0;
	endtask

	task automatic expect_char(input logic [31:0] cp, input logic bad);
		result_t r;
		r.code_point = bad ? 32'd0 : cp;
		r.malformed = bad;
		expected_chars.push_back(r);
	endtask

	task automatic gather_byte(input logic [7:0] b, input logic [1:0] last_pos,
			output logic done);
		if (msb_first)
			partial = {partial[23:0], b};
		else
			partial = partial | ({24'd0, b} << (8 * unit_pos));
		done = (unit_pos == last_pos);
		unit_pos = done ? 2'd0 : unit_pos + 2'd1;
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic        done;
		logic [15:0] unit;
		int          ones;
		case (enc_mode)
		ENC_UTF8: begin
			if (cont_left != 2'd0) begin
				if (b == 8'd0 || (b & CONT_MASK) != CONT_TAG)
					cont_bad = 1'b1;
				partial = {partial[25:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					expect_char(partial, cont_bad);
					partial = '0;
					cont_bad = 1'b0;
				end
			end else if (!b[7]) begin
				expect_char({24'd0, b}, 1'b0);
			end else begin
				ones = 0;
				while (ones < 8 && b[7 - ones])
					ones++;
				if (ones < 2 || ones > 4) begin
					expect_char('0, 1'b1);
				end else begin
					partial = {24'd0, b & (8'hff >> (ones + 1))};
					cont_left = 2'(ones - 1);
					cont_bad = 1'b0;
				end
			end
		end
		ENC_UTF16: begin
			gather_byte(b, 2'd1, done);
			if (done) begin
				unit = partial[15:0];
				partial = '0;
				if (pend_high_valid) begin
					pend_high_valid = 1'b0;
					if ((unit & SURR_MASK) != SURR_LOW)
						expect_char('0, 1'b1);
					else
						expect_char(SUPP_BASE + {12'd0, pend_high, unit[9:0]}, 1'b0);
					pend_high = '0;
				end else if ((unit & SURR_MASK) == SURR_HIGH) begin
					pend_high = unit[9:0];
					pend_high_valid = 1'b1;
				end else begin
					expect_char({16'd0, unit}, 1'b0);
				end
			end
		end
		ENC_UTF32: begin
			gather_byte(b, 2'd3, done);
			if (done) begin
				expect_char(partial, 1'b0);
				partial = '0;
			end
		end
		default: begin
			expect_char({24'd0, b}, 1'b0);
		end
		endcase
	endtask

	// Delivered words are checked before the byte of the same edge is decoded, as the
	// result of that byte cannot leave the decoder in the same cycle.
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			enc_mode = ENC_ASCII;
			msb_first = 1'b0;
			clear_decode();
			expected_chars.delete();
			mismatch_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", m_tdata));
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== want.code_point)
						report_mismatch($sformatf("code point %h, expected %h",
							m_tdata, want.code_point));
					if (m_tuser[0] !== want.malformed)
						report_mismatch($sformatf("malformed flag %b, expected %b",
							m_tuser[0], want.malformed));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ENCODING) begin
					enc_mode = enc_t'(cfg_data[1:0]);
					clear_decode();
				end else if (cfg_index == CFG_BIG_ENDIAN) begin
					msb_first = cfg_data[0];
					clear_decode();
				end
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata);
		end
		open_results <= expected_chars.size();
	end

endmodule

@@ tb/sv/tb_text_character_decoder_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the text character decoder: drives directed and random byte
// streams in every encoding and byte order and gives the verdict.
// Depends on tcd_pkg, text_character_decoder_top and code_point_checker.
module tb_text_character_decoder_top;
	import tcd_pkg::*;

	localparam int PHASES      = 12;
	localparam int PHASE_BYTES = 104;
	localparam int IDLE_LIMIT  = 2000;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   open_results;
	int   mismatch_count;
	int   idle_cycles = 0;
	int   bytes_sent = 0;
	bit   steady = 1'b0;
	enc_t mode = ENC_ASCII;
	logic order = 1'b0;

	always #1 clk = ~clk;

	text_character_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	code_point_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.open_results   (open_results),
		.mismatch_count (mismatch_count)
	);

	always @(posedge clk)
		m_tready <= steady || ($urandom_range(99) >= 8);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_text_character_decoder_top: errors");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_unit(input logic [31:0] value, input int nbytes, input logic msb);
		int pos;
		for (int k = 0; k < nbytes; k++) begin
			pos = msb ? nbytes - 1 - k : k;
			send_byte(value[8 * pos +: 8]);
		end
	endtask

	task automatic send_utf8_char(input int len, input bit broken);
		logic [7:0]  seq [4];
		logic [20:0] cp;
		int          bad_pos;
		cp = 21'($urandom);
		for (int k = len - 1; k > 0; k--) begin
			seq[k] = {2'b10, cp[5:0]};
			cp = cp >> 6;
		end
		case (len)
		1: seq[0] = {1'b0, cp[6:0]};
		2: seq[0] = {3'b110, cp[4:0]};
		3: seq[0] = {4'b1110, cp[3:0]};
		default: seq[0] = {5'b11110, cp[2:0]};
		endcase
		if (broken && len > 1) begin
			bad_pos = $urandom_range(len - 1, 1);
			seq[bad_pos] = $urandom_range(1) ? 8'h00 : 8'($urandom);
		end
		for (int k = 0; k < len; k++)
			send_byte(seq[k]);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// A byte that completes nothing may still be in flight when the last word has
	// arrived, so drain keeps waiting after that before any register write.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (open_results != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input enc_t enc, input logic msb, input logic spare);
		drain();
		write_reg(CFG_ENCODING, enc);
		write_reg(CFG_BIG_ENDIAN, {spare, msb});
		mode = enc;
		order = msb;
	endtask

	initial begin
		logic [7:0] burst[$];
		int         pick;
		bit         spare_done;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ENCODING;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00);
		send_byte(8'hff);

		set_mode(ENC_UTF8, 1'b0, 1'b0);
		burst = '{8'hc3, 8'ha9, 8'hf0, 8'h9f, 8'h98, 8'h80,
			8'h80, 8'hf8, 8'hc3, 8'h00, 8'hc3, 8'h41};
		foreach (burst[i])
			send_byte(burst[i]);

		set_mode(ENC_UTF16, 1'b0, 1'b1);
		burst = '{8'h3d, 8'hd8, 8'h00, 8'hde, 8'h00, 8'hd8, 8'h41, 8'h00, 8'h00, 8'hdc};
		foreach (burst[i])
			send_byte(burst[i]);

		// A write to an unused index must leave the half-received unit intact, while
		// a real register write drops it.
		set_mode(ENC_UTF32, 1'b1, 1'b0);
		send_byte(8'h12);
		send_byte(8'h34);
		drain();
		write_reg(CFG_SPARE_HI, 2'b11);
		send_byte(8'h56);
		send_byte(8'h78);
		send_byte(8'hab);

		for (int p = 0; p < PHASES; p++) begin
			set_mode(enc_t'(p % 4), ((p / 4) % 2) == 1, 1'($urandom));
			steady = (p == 6);
			bytes_sent = 0;
			spare_done = 1'b0;
			while (bytes_sent < PHASE_BYTES) begin
				if (!spare_done && bytes_sent >= PHASE_BYTES / 2) begin
					drain();
					write_reg(p[0] ? CFG_SPARE_HI : CFG_SPARE_LO, 2'($urandom));
					spare_done = 1'b1;
				end
				pick = $urandom_range(99);
				case (mode)
				ENC_ASCII: begin
					send_byte(8'($urandom));
				end
				ENC_UTF8: begin
					if (pick < 10)
						send_byte(8'($urandom));
					else
						send_utf8_char($urandom_range(4, 1), pick < 22);
				end
				ENC_UTF16: begin
					if (pick < 25) begin
						send_unit({16'd0, SURR_HIGH | 16'($urandom_range(1023))}, 2, order);
						send_unit({16'd0, SURR_LOW | 16'($urandom_range(1023))}, 2, order);
					end else if (pick < 35) begin
						send_byte(8'($urandom));
					end else begin
						send_unit({16'd0, 16'($urandom)}, 2, order);
					end
				end
				default: begin
					if (pick < 30)
						send_unit($urandom_range(32'h0010_ffff), 4, order);
					else
						send_unit($urandom, 4, order);
				end
				endcase
			end
		end
		steady = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0 && open_results == 0)
			$display("tb_text_character_decoder_top: clean");
		else
			$display("tb_text_character_decoder_top: errors");
		$finish;
	end

endmodule
